// ----- rtl/core/msve_pkg.sv -----
// Shared widths, types and constants of the multichannel velocity estimator.
`default_nettype none

package msve_pkg;

  localparam int CHANNELS    = 12;
  localparam int SAMPLE_BITS = 16;

  // Older samples kept per channel; the new sample makes the sixth tap.
  localparam int HIST_TAPS = 5;

  localparam int JOINT_BITS = 4;
  localparam int GAIN_BITS  = 24;
  localparam int VEL_BITS   = 32;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'd7314;

  localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // The sum of absolute weights is 18, below 2^5.
  localparam int WSUM_BITS = SAMPLE_BITS + 5;
  localparam int PROD_BITS = WSUM_BITS + GAIN_BITS + 1;
  localparam int SH_BITS   = PROD_BITS - 8;
  localparam int SAT_BITS  = (SH_BITS > VEL_BITS) ? SH_BITS : VEL_BITS + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [HIST_TAPS-1:0][SAMPLE_BITS-1:0] hist_row_t;
  typedef logic [CH_AW-1:0] ch_addr_t;
  typedef logic signed [WSUM_BITS-1:0] wsum_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SH_BITS-1:0] sh_t;
  typedef logic signed [SAT_BITS-1:0] sat_t;

  typedef struct packed {
    logic      en;
    ch_addr_t  addr;
    hist_row_t data;
  } hist_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/multichannel_savgol_velocity_estimator.sv -----
// Top level of the multichannel six-point Savitzky-Golay velocity estimator.
`default_nettype none

// When the output is not stalled it takes one position word per cycle, tagged
// with its joint, and returns one velocity word per input word, in order; it
// sustains one word per clock. Each joint keeps its last five samples in one
// row of a synchronous history memory with a registered read. The row is read
// when a word is accepted, the slope -5,-3,-1,1,3,5 (oldest first) is formed
// from it and the new sample, and the shifted row is written back in the same
// stage; a write and a read of the same joint in one cycle is forwarded, so
// back-to-back words of one joint see each other. Stages: history read,
// weighted sum and write-back, gain multiply, then round and saturate into
// the output register. The gain (Q8, 1/(35*dt), reset 7314 for 1 ms) is
// written through velocity_gain_we/data; the user must write it only while
// the block is idle, which the block does not enforce. History rows read as
// zero after reset until first written, with no clearing pass. A joint index
// beyond the channel count leaves the history alone and yields velocity zero.
module multichannel_savgol_velocity_estimator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                velocity_gain_we,
  input  wire logic [msve_pkg::GAIN_BITS-1:0]      velocity_gain_data,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire logic [msve_pkg::JOINT_BITS-1:0]     joint_index,
  input  wire logic signed [msve_pkg::SAMPLE_BITS-1:0] joint_position,
  output logic                                     velocity_valid,
  input  wire logic                                velocity_stall,
  output logic [msve_pkg::JOINT_BITS-1:0]          velocity_joint,
  output logic signed [msve_pkg::VEL_BITS-1:0]     joint_velocity
);
  import msve_pkg::*;

  logic [GAIN_BITS-1:0] gain;

  // Stage 1: history row arriving from the memory
  logic                  s1_valid;
  logic                  s1_inrange;
  logic [JOINT_BITS-1:0] s1_joint;
  ch_addr_t              s1_addr;
  sample_t               s1_sample;

  // Stage 2: weighted sum
  logic                  s2_valid;
  logic [JOINT_BITS-1:0] s2_joint;
  wsum_t                 s2_wsum;

  // Stage 3: scaled product
  logic                  s3_valid;
  logic [JOINT_BITS-1:0] s3_joint;
  prod_t                 s3_prod;

  logic out_en, en3, en2, en1;
  logic accept;
  logic in_range;
  ch_addr_t in_addr;

  hist_row_t hist;
  hist_wr_t  hist_wr;
  wsum_t     wsum_next;
  prod_t     prod_next;
  prod_t     rounded;
  sh_t       shifted;
  sat_t      shifted_ext;
  logic signed [VEL_BITS-1:0] vel_next;

  // Handshake chain: each stage loads when it is empty or its word moves on.
  assign out_en       = !velocity_valid || !velocity_stall;
  assign en3          = !s3_valid || out_en;
  assign en2          = !s2_valid || en3;
  assign en1          = !s1_valid || en2;
  assign sample_stall = !en1;
  assign accept       = sample_valid && en1;

  assign in_range = 32'(joint_index) < CHANNELS;
  assign in_addr  = CH_AW'(joint_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (velocity_gain_we) begin
      gain <= velocity_gain_data;
    end
  end

  // Write the shifted row back as the word leaves stage 1.
  assign hist_wr.en   = s1_valid && s1_inrange && en2;
  assign hist_wr.addr = s1_addr;
  assign hist_wr.data = {s1_sample, hist[HIST_TAPS-1:1]};

  msve_hist_ram u_hist (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_range),
    .rd_addr (in_addr),
    .wr      (hist_wr),
    .rd_data (hist)
  );

  // Slope weights folded in pairs: 5*(s-h0) + 3*(h4-h1) + (h3-h2).
  always_comb begin
    wsum_t d5, d3, d1;
    d5 = wsum_t'(s1_sample) - wsum_t'(signed'(hist[0]));
    d3 = wsum_t'(signed'(hist[4])) - wsum_t'(signed'(hist[1]));
    d1 = wsum_t'(signed'(hist[3])) - wsum_t'(signed'(hist[2]));
    if (s1_inrange) begin
      wsum_next = (d5 <<< 2) + d5 + (d3 <<< 1) + d3 + d1;
    end else begin
      // out-of-range joint: zero sum gives zero velocity
      wsum_next = '0;
    end
  end

  assign prod_next = prod_t'(s2_wsum) * prod_t'(signed'({1'b0, gain}));

  // Round half up, drop the Q8 fraction, then clamp to 32 bits.
  always_comb begin
    rounded     = s3_prod + prod_t'(128);
    shifted     = sh_t'(rounded >>> 8);
    shifted_ext = sat_t'(shifted);
    priority if (shifted_ext > sat_t'(32'sh7FFF_FFFF)) begin
      vel_next = 32'sh7FFF_FFFF;
    end else if (shifted_ext < sat_t'(32'sh8000_0000)) begin
      vel_next = 32'sh8000_0000;
    end else begin
      vel_next = VEL_BITS'(shifted_ext);
    end
  end

  // Control: valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      s3_valid       <= 1'b0;
      velocity_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= sample_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        s3_valid <= s2_valid;
      end
      if (out_en) begin
        velocity_valid <= s3_valid;
      end
    end
  end

  // Payload: hold while stalled, advance otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_inrange <= in_range;
      s1_joint   <= joint_index;
      s1_addr    <= in_addr;
      s1_sample  <= joint_position;
    end
    if (en2 && s1_valid) begin
      s2_joint <= s1_joint;
      s2_wsum  <= wsum_next;
    end
    if (en3 && s2_valid) begin
      s3_joint <= s2_joint;
      s3_prod  <= prod_next;
    end
    if (out_en && s3_valid) begin
      velocity_joint <= s3_joint;
      joint_velocity <= vel_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/msve_hist_ram.sv -----
// Per-channel sample history memory with valid bits and write-to-read forwarding.
`default_nettype none

module msve_hist_ram (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rd_en,
  input  wire msve_pkg::ch_addr_t  rd_addr,
  input  wire msve_pkg::hist_wr_t  wr,
  output msve_pkg::hist_row_t    rd_data
);
  import msve_pkg::*;

  hist_row_t mem [CHANNELS];
  logic [CHANNELS-1:0] entry_valid;

  hist_row_t mem_q;
  hist_row_t fwd_q;
  logic      hit_q;
  logic      valid_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
      fwd_q <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      hit_q       <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        // forward a write to the same entry in the same cycle
        hit_q   <= wr.en && (wr.addr == rd_addr);
        valid_q <= entry_valid[rd_addr];
      end
    end
  end

  always_comb begin
    if (hit_q) begin
      rd_data = fwd_q;
    end else if (valid_q) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Testbench for the multichannel six-point Savitzky-Golay velocity estimator.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import msve_pkg::*;

  // Give up well past the slowest legal run.
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;
  localparam logic [GAIN_BITS-1:0] GAIN_MIN = 24'd1;
  localparam logic [GAIN_BITS-1:0] GAIN_ZERO = '0;
  localparam logic signed [SAMPLE_BITS-1:0] POS_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] POS_MIN = 16'sh8000;

  typedef logic [JOINT_BITS-1:0] joint_t;
  typedef logic signed [VEL_BITS-1:0] velocity_t;

  typedef struct {
    joint_t    joint;
    velocity_t velocity;
  } velocity_word_t;

  // Predicts each velocity word from the per-joint sample history and the gain,
  // and checks the output words against the predictions in order.
  class savgol_velocity_checker;
    localparam int ROUND_HALF = 128;
    localparam int GAIN_FRAC_BITS = 8;
    localparam longint VEL_HIGH = 64'sd2147483647;
    localparam longint VEL_LOW = -64'sd2147483648;

    sample_t position_history [CHANNELS][HIST_TAPS];
    logic [GAIN_BITS-1:0] gain;
    velocity_word_t expected_velocity [$];
    int mismatches;

    function new();
      foreach (position_history[c, k]) position_history[c][k] = '0;
      gain = GAIN_RESET;
      mismatches = 0;
    endfunction

    function void set_gain(logic [GAIN_BITS-1:0] g);
      gain = g;
    endfunction

    function int pending();
      return expected_velocity.size();
    endfunction

    // Weighted slope -5,-3,-1,1,3,5 over the five held samples plus the new one.
    function void note_position(joint_t j, sample_t p);
      longint slope_sum;
      longint scaled;
      velocity_word_t w;
      slope_sum = 0;
      w.joint = j;
      w.velocity = '0;
      if (j < CHANNELS) begin
        for (int k = 0; k < HIST_TAPS; k++)
          slope_sum += longint'(2 * k - 5) * longint'(position_history[j][k]);
        slope_sum += longint'(2 * HIST_TAPS - 5) * longint'(p);
        scaled = (slope_sum * longint'(gain) + ROUND_HALF) >>> GAIN_FRAC_BITS;
        if (scaled > VEL_HIGH) w.velocity = velocity_t'(VEL_HIGH);
        else if (scaled < VEL_LOW) w.velocity = velocity_t'(VEL_LOW);
        else w.velocity = velocity_t'(scaled);
        for (int k = 0; k < HIST_TAPS - 1; k++)
          position_history[j][k] = position_history[j][k + 1];
        position_history[j][HIST_TAPS - 1] = p;
      end
      expected_velocity.push_back(w);
    endfunction

    function void check_velocity(joint_t j, velocity_t v);
      velocity_word_t w;
      if (expected_velocity.size() == 0) begin
        $display("%0t: unexpected velocity word joint %0d velocity %0d", $time, j, v);
        mismatches++;
        return;
      end
      w = expected_velocity.pop_front();
      if (j !== w.joint) begin
        $display("%0t: velocity_joint expected %0d actual %0d", $time, w.joint, j);
        mismatches++;
      end
      if (v !== w.velocity) begin
        $display("%0t: joint_velocity expected %0d actual %0d (joint %0d)",
                 $time, w.velocity, v, w.joint);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic velocity_gain_we = 1'b0;
  logic [GAIN_BITS-1:0] velocity_gain_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  joint_t joint_index = '0;
  sample_t joint_position = '0;
  logic velocity_valid;
  logic velocity_stall = 1'b0;
  joint_t velocity_joint;
  velocity_t joint_velocity;

  savgol_velocity_checker sb;
  int cycle_count = 0;
  bit phase_done = 1'b0;
  int send_idle_pct = 0;

  // Per-joint trajectories for the smooth random stimulus.
  sample_t track_pos [1 << JOINT_BITS];
  joint_t last_joint = '0;

  multichannel_savgol_velocity_estimator u_top (
    .clk               (clk),
    .rst               (rst),
    .velocity_gain_we  (velocity_gain_we),
    .velocity_gain_data(velocity_gain_data),
    .sample_valid      (sample_valid),
    .sample_stall      (sample_stall),
    .joint_index       (joint_index),
    .joint_position    (joint_position),
    .velocity_valid    (velocity_valid),
    .velocity_stall    (velocity_stall),
    .velocity_joint    (velocity_joint),
    .joint_velocity    (joint_velocity)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge, before the block's registers
  // move. Note the accepted position word first, then check any velocity word.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && !sample_stall)
        sb.note_position(joint_index, joint_position);
      if (velocity_valid && !velocity_stall)
        sb.check_velocity(velocity_joint, joint_velocity);
    end
  end

  // Offer one position word and hold it until the block takes it. Call and
  // return at a falling edge; valid stays high for a following word.
  task automatic send_sample(input joint_t j, input sample_t p);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    joint_index <= j;
    joint_position <= p;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  // Drive the output stall for one phase: an optional long hold-off first,
  // counted here, then random stalls until the phase has drained.
  task automatic drive_stall(input int stall_pct, input int hold);
    int left;
    bit quit;
    left = hold;
    quit = 1'b0;
    while (!quit) begin
      @(negedge clk);
      if (phase_done) begin
        quit = 1'b1;
      end else if (left > 0) begin
        velocity_stall <= 1'b1;
        left--;
      end else begin
        velocity_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
    velocity_stall <= 1'b0;
  endtask

  task automatic write_gain(input logic [GAIN_BITS-1:0] g);
    velocity_gain_we <= 1'b1;
    velocity_gain_data <= g;
    @(negedge clk);
    velocity_gain_we <= 1'b0;
    sb.set_gain(g);
  endtask

  // Directed words: field extremes, back-to-back joints, out-of-range joints,
  // saturation at the largest gain, zero gain and rounding at the smallest.
  task automatic play_directed(input int section);
    case (section)
      0: begin
        send_sample(4'd0, POS_MAX);
        send_sample(4'd0, POS_MAX);
        send_sample(4'd0, POS_MIN);
        send_sample(4'd11, POS_MIN);
        send_sample(4'd0, POS_MAX);
        send_sample(4'd11, POS_MIN);
        send_sample(4'd12, 16'sh1234);
        send_sample(4'd15, POS_MIN);
        send_sample(4'd0, 16'sh0000);
        for (int k = 0; k < 6; k++) send_sample(4'd5, sample_t'(100 * k));
      end
      1: begin
        send_sample(4'd1, POS_MAX);
        send_sample(4'd2, POS_MIN);
        send_sample(4'd1, POS_MIN);
      end
      2: begin
        send_sample(4'd3, POS_MAX);
        send_sample(4'd5, 16'sd600);
      end
      default: begin
        send_sample(4'd5, 16'sd700);
        send_sample(4'd6, -16'sd1);
        send_sample(4'd7, 16'sd1);
      end
    endcase
  endtask

  // Mostly smooth trajectories with runs on one joint; the rest is noise,
  // rail values and joints beyond the channel count.
  task automatic play_random(input int count);
    int kind;
    joint_t j;
    sample_t p;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      if ($urandom_range(99) < 40) j = last_joint;
      else j = joint_t'($urandom_range(CHANNELS - 1));
      if (kind < 70) begin
        track_pos[j] = track_pos[j] + sample_t'($urandom_range(4095)) - 16'sd2048;
        p = track_pos[j];
      end else if (kind < 85) begin
        p = sample_t'($urandom_range(16'hFFFF));
      end else if (kind < 92) begin
        case ($urandom_range(3))
          0: p = POS_MAX;
          1: p = POS_MIN;
          2: p = '0;
          default: p = -16'sd1;
        endcase
      end else begin
        j = joint_t'($urandom_range((1 << JOINT_BITS) - 1, CHANNELS));
        p = sample_t'($urandom_range(16'hFFFF));
      end
      last_joint = j;
      send_sample(j, p);
    end
  endtask

  // One phase: write the gain while idle (negative means leave it), then run
  // sender and receiver together until every expected word has come back.
  task automatic run_phase(input longint gain, input int idle_pct, input int stall_pct,
                           input int hold, input int section, input int count);
    if (gain >= 0) write_gain(GAIN_BITS'(gain));
    send_idle_pct = idle_pct;
    phase_done = 1'b0;
    fork
      begin
        if (section >= 0) play_directed(section);
        else play_random(count);
        sample_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        phase_done = 1'b1;
      end
      drive_stall(stall_pct, hold);
    join
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    foreach (track_pos[i]) track_pos[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: reset gain first, then the gain extremes.
    run_phase(-1, 0, 0, 0, 0, 0);
    run_phase(GAIN_MAX, 0, 0, 0, 1, 0);
    run_phase(GAIN_ZERO, 0, 0, 0, 2, 0);
    run_phase(GAIN_MIN, 0, 0, 0, 3, 0);

    // Random part across idling patterns and gains.
    run_phase(GAIN_RESET, 0, 0, 0, -1, 110);
    run_phase($urandom_range(GAIN_MAX, 1), 51, 0, 0, -1, 110);
    run_phase($urandom_range(65535, 1), 0, 51, 0, -1, 110);
    run_phase(GAIN_MAX, 10, 10, 0, -1, 110);
    // Long output hold-off with the sender pushing every cycle: fill the
    // pipeline until the block stalls its input.
    run_phase($urandom_range(GAIN_MAX, 1), 0, 0, 80, -1, 110);

    // Let any stray word surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/msve_pkg.sv
rtl/core/msve_hist_ram.sv
rtl/core/multichannel_savgol_velocity_estimator.sv
tb/testbench.sv
